[sv/sbq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_pkg: shared types and codes for the semaphore blocked queue table
// Holds the action and status codes and the field widths of both channels.
// ----------------------------------------------------------------------------
package sbq_pkg;

    localparam int ACTION_W = 2;
    localparam int KEY_IN_W = 32;
    localparam int PROC_W   = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_BLOCK   = 2'd0,
        ACT_UNBLOCK = 2'd1,
        ACT_OUT     = 2'd2,
        ACT_PEEK    = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2,
        ST_BADKEY = 2'd3
    } status_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_IN_W-1:0] sem_key;
        logic [PROC_W-1:0]   proc_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PROC_W-1:0]   out_proc;
        logic                proc_valid;
    } rsp_t;

endpackage

[sv/sbq_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_req_if / sbq_rsp_if: valid-ready channels of the queue table
// An item moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface sbq_req_if;
    logic          valid;
    logic          ready;
    sbq_pkg::req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sbq_rsp_if;
    logic          valid;
    logic          ready;
    sbq_pkg::rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/semaphore_blocked_queue_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semaphore_blocked_queue_table: active semaphore list with blocked queues
// Descriptor table keyed by semaphore address, each with a FIFO of process
// ids kept as a doubly linked list through per-process links.
// ----------------------------------------------------------------------------
// One item at a time. A block or a lookup walks the descriptors one per cycle
// through a single shared key comparator; this walk sets the time such an
// item takes. A remove reads the descriptor of the named process instead of
// walking. After the walk or that read, the head and tail are read, then the
// links of the target; a block appends behind the tail, an unblock or a
// remove unlinks the target. An absent key or a full table is answered after
// the walk, a rejected key or process without it. The free descriptor is
// taken during the same walk (lowest free index). Each table is a memory read
// at one address per cycle with a registered read; only the active and queued
// flags are flip-flops cleared by reset, so no clearing pass is needed. The
// result waits in an output register; in.ready rises again the cycle after it has been taken.
module semaphore_blocked_queue_table #(
    parameter int MAX_PROCS = 32,
    parameter int KEY_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    sbq_req_if.sink    in,
    sbq_rsp_if.source  out
);

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = IW + 1;
    localparam int PW = sbq_pkg::PROC_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SCAN, S_SCAN_END, S_RD1, S_RD2, S_UNLINK, S_RESP
    } state_t;

    // descriptor and process memories
    logic [KEY_WIDTH-1:0] key_mem  [MAX_PROCS];
    logic [IW-1:0]        head_mem [MAX_PROCS];
    logic [IW-1:0]        tail_mem [MAX_PROCS];
    logic [IW-1:0]        next_mem [MAX_PROCS];
    logic [IW-1:0]        prev_mem [MAX_PROCS];
    logic [IW-1:0]        pdesc_mem[MAX_PROCS];
    logic [MAX_PROCS-1:0] active_reg, queued_reg;

    state_t               state_reg;
    sbq_pkg::action_t     act_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [IW-1:0]        p_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 found_reg, free_ok_reg;
    logic [IW-1:0]        d_reg, free_reg;
    logic [IW-1:0]        h_reg, t_reg, nx_reg, pv_reg;
    logic [IW-1:0]        tgt_reg;       // process being unlinked
    logic [KEY_WIDTH-1:0] key_rd_reg;
    sbq_pkg::rsp_t        rsp_reg;
    logic                 out_valid_reg;

    logic [KEY_WIDTH-1:0] in_key;
    logic                 pid_ok;
    logic [IW-1:0]        scan_idx;
    logic [PW-1:0]        tgt_out;

    assign in_key   = KEY_WIDTH'(in.payload.sem_key);
    assign pid_ok   = (32'(in.payload.proc_id) < MAX_PROCS);
    assign scan_idx = cnt_reg[IW-1:0];
    assign tgt_out  = PW'(tgt_reg);

    assign in.ready        = (state_reg == S_IDLE) && !out_valid_reg;
    assign out.valid       = out_valid_reg;
    assign out.payload     = rsp_reg;

    // registered reads of all memories, one address each per cycle
    logic [IW-1:0] kaddr, paddr, daddr, pdaddr;
    always_comb
    begin
        kaddr  = scan_idx;
        daddr  = d_reg;
        paddr  = tgt_reg;
        // look up the owner of the named process at the accepting edge
        pdaddr = (state_reg == S_IDLE) ? IW'(in.payload.proc_id) : p_reg;
    end

    always_ff @(posedge clk)
    begin
        key_rd_reg <= key_mem[kaddr];
        h_reg      <= head_mem[daddr];
        t_reg      <= tail_mem[daddr];
        nx_reg     <= next_mem[paddr];
        pv_reg     <= prev_mem[paddr];
    end

    // memory writes (driven by the sequencer below)
    logic                 wk_en, wh_en, wt_en, wn_en, wp_en, wd_en;
    logic [IW-1:0]        wk_a, wh_a, wt_a, wn_a, wp_a, wd_a;
    logic [IW-1:0]        wh_d, wt_d, wn_d, wp_d, wd_d;

    always_ff @(posedge clk)
    begin
        if (wk_en) key_mem[wk_a]   <= key_reg;
        if (wh_en) head_mem[wh_a]  <= wh_d;
        if (wt_en) tail_mem[wt_a]  <= wt_d;
        if (wn_en) next_mem[wn_a]  <= wn_d;
        if (wp_en) prev_mem[wp_a]  <= wp_d;
        if (wd_en) pdesc_mem[wd_a] <= wd_d;
    end

    logic [IW-1:0] pdesc_rd_reg;
    always_ff @(posedge clk)
    begin
        pdesc_rd_reg <= pdesc_mem[pdaddr];
    end

    logic key_hit;
    logic [IW-1:0] prev_idx;
    assign prev_idx = scan_idx - IW'(1);
    assign key_hit  = active_reg[prev_idx] && (key_rd_reg == key_reg);

    always_comb
    begin
        wk_en = 1'b0; wh_en = 1'b0; wt_en = 1'b0;
        wn_en = 1'b0; wp_en = 1'b0; wd_en = 1'b0;
        wk_a = free_reg; wh_a = d_reg; wt_a = d_reg;
        wn_a = t_reg; wp_a = p_reg; wd_a = p_reg;
        wh_d = p_reg; wt_d = p_reg; wn_d = p_reg; wp_d = t_reg; wd_d = d_reg;
        if (state_reg == S_RD2 && act_reg == sbq_pkg::ACT_BLOCK)
        begin
            if (found_reg)
            begin
                // append behind the current tail
                wn_en = 1'b1; wp_en = 1'b1; wt_en = 1'b1; wd_en = 1'b1;
            end
            else if (free_ok_reg)
            begin
                wk_en = 1'b1; wh_en = 1'b1; wt_en = 1'b1; wd_en = 1'b1;
                wh_a = free_reg; wt_a = free_reg; wd_d = free_reg;
            end
        end
        else if (state_reg == S_UNLINK)
        begin
            if (h_reg == tgt_reg && t_reg == tgt_reg)
            begin
            end
            else if (h_reg == tgt_reg)
            begin
                wh_en = 1'b1; wh_d = nx_reg;
            end
            else if (t_reg == tgt_reg)
            begin
                wt_en = 1'b1; wt_d = pv_reg;
            end
            else
            begin
                wn_en = 1'b1; wn_a = pv_reg; wn_d = nx_reg;
                wp_en = 1'b1; wp_a = nx_reg; wp_d = pv_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= '0;
            queued_reg    <= '0;
            out_valid_reg <= 1'b0;
            act_reg       <= sbq_pkg::ACT_BLOCK;
            key_reg       <= '0;
            p_reg         <= '0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            free_ok_reg   <= 1'b0;
            d_reg         <= '0;
            free_reg      <= '0;
            tgt_reg       <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && out.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in.valid && in.ready)
                    begin
                        act_reg     <= sbq_pkg::action_t'(in.payload.action);
                        key_reg     <= in_key;
                        p_reg       <= IW'(in.payload.proc_id);
                        cnt_reg     <= '0;
                        found_reg   <= 1'b0;
                        free_ok_reg <= 1'b0;
                        if (in.payload.action == sbq_pkg::ACT_OUT)
                        begin
                            if (!pid_ok || !queued_reg[IW'(in.payload.proc_id)])
                            begin
                                rsp_reg   <= '{sbq_pkg::ST_ABSENT, '0, 1'b0};
                                state_reg <= S_RESP;
                            end
                            else
                            begin
                                rsp_reg   <= '{sbq_pkg::ST_OK, '0, 1'b0};
                                state_reg <= S_DECODE;
                            end
                        end
                        else if (in_key == '0)
                        begin
                            rsp_reg   <= '{sbq_pkg::ST_BADKEY, '0, 1'b0};
                            state_reg <= S_RESP;
                        end
                        else if (in.payload.action == sbq_pkg::ACT_BLOCK &&
                                 (!pid_ok || queued_reg[IW'(in.payload.proc_id)]))
                        begin
                            rsp_reg   <= '{sbq_pkg::ST_ABSENT, '0, 1'b0};
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            rsp_reg   <= '{sbq_pkg::ST_OK, '0, 1'b0};
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_DECODE:
                begin
                    // remove: descriptor of the named process is now read
                    d_reg     <= pdesc_rd_reg;
                    tgt_reg   <= p_reg;
                    state_reg <= S_SCAN_END;
                end
                S_SCAN:
                begin
                    // key read of entry cnt-1 is valid once cnt is nonzero
                    if (cnt_reg != '0 && !found_reg && key_hit)
                    begin
                        found_reg <= 1'b1;
                        d_reg     <= prev_idx;
                    end
                    if (cnt_reg < CW'(MAX_PROCS) && !free_ok_reg && !active_reg[scan_idx])
                    begin
                        free_ok_reg <= 1'b1;
                        free_reg    <= scan_idx;
                    end
                    if (cnt_reg == CW'(MAX_PROCS))
                        state_reg <= S_SCAN_END;
                    else
                        cnt_reg <= cnt_reg + CW'(1);
                end
                S_SCAN_END:
                begin
                    // head/tail of d_reg being read
                    if (act_reg == sbq_pkg::ACT_OUT)
                        state_reg <= S_RD1;
                    else if (!found_reg)
                    begin
                        if (act_reg != sbq_pkg::ACT_BLOCK)
                        begin
                            rsp_reg.status <= sbq_pkg::ST_ABSENT;
                            state_reg      <= S_RESP;
                        end
                        else if (!free_ok_reg)
                        begin
                            rsp_reg.status <= sbq_pkg::ST_FULL;
                            state_reg      <= S_RESP;
                        end
                        else
                            state_reg <= S_RD1;
                    end
                    else
                        state_reg <= S_RD1;
                end
                S_RD1:
                begin
                    // head and tail now valid; read links of the target
                    if (act_reg == sbq_pkg::ACT_UNBLOCK || act_reg == sbq_pkg::ACT_PEEK)
                        tgt_reg <= h_reg;
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    unique case (act_reg)
                        sbq_pkg::ACT_BLOCK:
                        begin
                            queued_reg[p_reg] <= 1'b1;
                            if (!found_reg)
                                active_reg[free_reg] <= 1'b1;
                            state_reg <= S_RESP;
                        end
                        sbq_pkg::ACT_PEEK:
                        begin
                            rsp_reg   <= '{sbq_pkg::ST_OK, tgt_out, 1'b1};
                            state_reg <= S_RESP;
                        end
                        default:
                        begin
                            rsp_reg   <= '{sbq_pkg::ST_OK, tgt_out, 1'b1};
                            state_reg <= S_UNLINK;
                        end
                    endcase
                end
                S_UNLINK:
                begin
                    queued_reg[tgt_reg] <= 1'b0;
                    if (h_reg == tgt_reg && t_reg == tgt_reg)
                        active_reg[d_reg] <= 1'b0;
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
